[rtl/core/tvsp_pkg.sv]
// shared types and constants of the two-voice sample player
`default_nettype none

package tvsp_pkg;

  localparam int FIELD_W    = 16;
  localparam int SAMPLE_W   = 8;
  localparam int MIX_OFFSET = 128;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  // control group from the sequencer to the voice state
  typedef struct packed {
    logic adv;    // advance the selected voice
    logic sel;    // voice being advanced
    logic start;  // start item accepted
    logic stop;   // stop item accepted
  } vctl_t;

endpackage

`default_nettype wire

[rtl/core/tvsp_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module tvsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/tvsp_voices.sv]
// voice state of both voices with one shared advance unit
`default_nettype none

module tvsp_voices #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tvsp_pkg::vctl_t       ctl,
  input  wire logic [ADDR_BITS-1:0]  start_addr,
  input  wire logic [ADDR_BITS-1:0]  start_end,
  input  wire logic                  start_rep,
  output logic      [ADDR_BITS-1:0]  rd_addr,
  output logic                       sel_playing,
  output logic      [1:0]            playing
);
  import tvsp_pkg::*;

  localparam int POS_W = ADDR_BITS + 1;

  logic [1:0]           playing_r, playing_nxt;
  logic [1:0]           loops_r,   loops_nxt;
  logic [POS_W-1:0]     pos_r     [2];
  logic [POS_W-1:0]     pos_nxt   [2];
  logic [ADDR_BITS-1:0] end_r     [2];
  logic [ADDR_BITS-1:0] end_nxt   [2];
  logic [ADDR_BITS-1:0] lstart_r  [2];
  logic [ADDR_BITS-1:0] lstart_nxt[2];

  logic [POS_W-1:0] pos_inc;
  logic             at_end;
  logic             dup;
  logic             tgt;
  logic             take;

  assign pos_inc = pos_r[ctl.sel] + POS_W'(1);
  assign at_end  = (pos_inc >= {1'b0, end_r[ctl.sel]});
  assign dup     = (playing_r[0] && (end_r[0] == start_end)) ||
                   (playing_r[1] && (end_r[1] == start_end));
  assign tgt     = playing_r[0];
  assign take    = ctl.start && !dup;

  assign rd_addr     = pos_r[ctl.sel][ADDR_BITS-1:0];
  assign sel_playing = playing_r[ctl.sel];
  assign playing     = playing_r;

  always_comb begin
    playing_nxt = playing_r;
    loops_nxt   = loops_r;
    pos_nxt     = pos_r;
    end_nxt     = end_r;
    lstart_nxt  = lstart_r;
    if (ctl.adv && playing_r[ctl.sel]) begin
      pos_nxt[ctl.sel] = pos_inc;
      if (at_end) begin
        if (loops_r[ctl.sel]) begin
          pos_nxt[ctl.sel] = {1'b0, lstart_r[ctl.sel]};
        end else begin
          playing_nxt[ctl.sel] = 1'b0;
        end
      end
    end
    if (ctl.stop) begin
      end_nxt   = '{default: '0};
      loops_nxt = '0;
    end
    if (take) begin
      pos_nxt[tgt]     = {1'b0, start_addr};
      end_nxt[tgt]     = start_end;
      lstart_nxt[tgt]  = start_addr;
      loops_nxt[tgt]   = start_rep;
      playing_nxt[tgt] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= '0;
      loops_r   <= '0;
      pos_r     <= '{default: '0};
      end_r     <= '{default: '0};
      lstart_r  <= '{default: '0};
    end else begin
      playing_r <= playing_nxt;
      loops_r   <= loops_nxt;
      pos_r     <= pos_nxt;
      end_r     <= end_nxt;
      lstart_r  <= lstart_nxt;
    end
  end

  // a start that is taken leaves its voice playing
  a_start_plays: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> playing_r[$past(tgt)])
    else $error("started voice not playing");

endmodule

`default_nettype wire

[rtl/core/tvsp_mix.sv]
// saturating two-voice mixer with registered result
`default_nettype none

module tvsp_mix (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          pend,
  input  wire logic [tvsp_pkg::SAMPLE_W-1:0] byte0,
  input  wire logic                          use0,
  input  wire logic [tvsp_pkg::SAMPLE_W-1:0] byte1,
  input  wire logic                          use1,
  input  wire logic [1:0]                    act,
  output logic                               out_valid,
  output logic      [tvsp_pkg::SAMPLE_W-1:0] out_dac_sample,
  output logic                               out_voice_one_active,
  output logic                               out_voice_two_active
);
  import tvsp_pkg::*;

  logic [SAMPLE_W-1:0] b0g, b1g;
  logic [SAMPLE_W:0]   sum, adj;
  logic [SAMPLE_W-1:0] dac;

  assign b0g = use0 ? byte0 : '0;
  assign b1g = use1 ? byte1 : '0;
  assign sum = {1'b0, b0g} + {1'b0, b1g};

  always_comb begin
    adj = sum;
    if (act[0] && act[1]) begin
      if (sum < (SAMPLE_W + 1)'(MIX_OFFSET)) begin
        adj = '0;
      end else begin
        adj = sum - (SAMPLE_W + 1)'(MIX_OFFSET);
      end
    end
    dac = adj[SAMPLE_W] ? '1 : adj[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pend;
    end
    out_dac_sample       <= dac;
    out_voice_one_active <= act[0];
    out_voice_two_active <= act[1];
  end

endmodule

`default_nettype wire

[rtl/core/two_voice_sample_player_top.sv]
// top level of the two-voice sample player
`default_nettype none

// two-voice 8-bit pcm sample player. items enter on start while busy is low;
// in_op picks tick, start voice, stop all or write sample byte; stop ends
// every voice at its next advance. write, start and stop give no result. on a
// tick the single sample memory port reads voice one in the accept cycle and
// voice two in the following busy cycle, during which no item is accepted.
// the mixed result appears on the out_ ports with out_valid high for exactly
// one cycle, after the tick's second read has passed through pend_r and the
// mixer's output register; it cannot be held off, so the receiver must take
// it in that cycle. results come out in tick order.
// sample memory holds 2^ADDR_BITS bytes and is not cleared at reset; voices
// must only play addresses that have been written.
module two_voice_sample_player_top #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_op,
  input  wire logic [tvsp_pkg::FIELD_W-1:0]  in_address,
  input  wire logic [tvsp_pkg::FIELD_W-1:0]  in_end_address,
  input  wire logic                          in_repeat_req,
  input  wire logic [tvsp_pkg::SAMPLE_W-1:0] in_write_byte,
  output logic                               out_valid,
  output logic      [tvsp_pkg::SAMPLE_W-1:0] out_dac_sample,
  output logic                               out_voice_one_active,
  output logic                               out_voice_two_active
);
  import tvsp_pkg::*;

  // fields narrower than the address width are zero-extended
  localparam int CW = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;

  typedef enum logic {
    ST_FIRST,   // idle, or accept cycle reading voice one
    ST_SECOND   // second tick cycle reading voice two
  } state_t;

  state_t state_r, state_nxt;

  logic                 accept;
  logic                 tick_acc;
  op_t                  op;
  vctl_t                ctl;
  logic [ADDR_BITS-1:0] addr_in;
  logic [ADDR_BITS-1:0] end_in;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 sel_playing;
  logic [1:0]           playing;
  logic                 ram_we;
  logic                 ram_en;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [SAMPLE_W-1:0]  ram_rdata;

  // per-tick holding registers
  logic                 pend_r;   // voice two byte is on the ram output
  logic                 use0_r;   // voice one played this tick
  logic                 use1_r;   // voice two played this tick
  logic [SAMPLE_W-1:0]  byte0_r;  // voice one byte

  assign op       = op_t'(in_op);
  assign busy     = (state_r == ST_SECOND);
  assign accept   = start && !busy;
  assign tick_acc = accept && (op == OP_TICK);

  assign addr_in = ADDR_BITS'(in_address[CW-1:0]);
  assign end_in  = ADDR_BITS'(in_end_address[CW-1:0]);

  // voice one advances in the accept cycle, voice two in the busy cycle
  assign ctl.adv   = tick_acc || busy;
  assign ctl.sel   = busy;
  assign ctl.start = accept && (op == OP_START);
  assign ctl.stop  = accept && (op == OP_STOP);

  // memory port: sample writes, otherwise the selected voice position
  assign ram_we   = accept && (op == OP_WRITE);
  assign ram_en   = ram_we || ctl.adv;
  assign ram_addr = ram_we ? addr_in : rd_addr;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FIRST:  if (tick_acc) state_nxt = ST_SECOND;
      ST_SECOND: state_nxt = ST_FIRST;
      default:   state_nxt = ST_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FIRST;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= busy;
    end
    if (tick_acc) begin
      use0_r <= sel_playing;
    end
    if (busy) begin
      byte0_r <= ram_rdata;
      use1_r  <= sel_playing;
    end
  end

  tvsp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (2 ** ADDR_BITS)
  ) u_sample_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_write_byte),
    .rdata (ram_rdata)
  );

  tvsp_voices #(
    .ADDR_BITS (ADDR_BITS)
  ) u_voices (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .start_addr  (addr_in),
    .start_end   (end_in),
    .start_rep   (in_repeat_req),
    .rd_addr     (rd_addr),
    .sel_playing (sel_playing),
    .playing     (playing)
  );

  // flags after the tick are the voice state once voice two has advanced
  tvsp_mix u_mix (
    .clk                  (clk),
    .rst_n                (rst_n),
    .pend                 (pend_r),
    .byte0                (byte0_r),
    .use0                 (use0_r),
    .byte1                (ram_rdata),
    .use1                 (use1_r),
    .act                  (playing),
    .out_valid            (out_valid),
    .out_dac_sample       (out_dac_sample),
    .out_voice_one_active (out_voice_one_active),
    .out_voice_two_active (out_voice_two_active)
  );

  // the second tick cycle only follows an accepted tick
  a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $past(start && !busy && (in_op == OP_TICK)))
    else $error("busy without a tick");

  // busy lasts a single cycle
  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy longer than one cycle");

  // each result follows the second read of a tick
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy, 2))
    else $error("result without a tick");

endmodule

`default_nettype wire
